### src/sch_pkg.sv
// Shared types, constants and helper functions of the smoothed compass heading block.
package sch_pkg;

  localparam int MaxSteps       = 24;
  localparam int CordicStepsDef = 16;
  localparam int StepW          = $clog2(MaxSteps);
  localparam int CordW          = 34;

  localparam logic [31:0] TurnHalf    = 32'h8000_0000;
  localparam logic [31:0] TurnQuarter = 32'h4000_0000;
  localparam logic [31:0] InvGainQ30  = 32'h26DD_3B6A;

  localparam logic [8:0]  GainReset = 9'd64;
  localparam logic [8:0]  GainMax   = 9'd256;
  localparam logic [15:0] SineReset = 16'h0000;
  localparam logic [15:0] CosReset  = 16'h7FFF;

  // Configuration register indexes
  localparam logic RegDecl = 1'b0;
  localparam logic RegGain = 1'b1;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_cmd_t;

  // Arctangent of 2^-i in binary angle units (full turn = 2^32)
  function automatic logic [31:0] atan_lut(input logic [StepW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // Clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/sch_cordic.sv
// Iterative CORDIC unit: vectoring (angle of x,y) or rotation (sine and cosine of an angle).
module sch_cordic #(
  parameter int Steps = sch_pkg::CordicStepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sch_pkg::cordic_cmd_t     cmd_i,
  input  logic signed [15:0]       x_i,
  input  logic signed [15:0]       y_i,
  input  logic [31:0]              theta_i,
  output logic                     done_o,
  output logic [31:0]              angle_o,
  output logic signed [15:0]       sin_o,
  output logic signed [15:0]       cos_o
);

  localparam int NRun = (Steps > sch_pkg::MaxSteps) ? sch_pkg::MaxSteps : Steps;
  localparam logic [sch_pkg::StepW-1:0] LastStep = sch_pkg::StepW'(NRun - 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic                              rot_q, rot_d;
  logic                              neg_q, neg_d;
  logic [sch_pkg::StepW-1:0]         step_q, step_d;
  logic signed [sch_pkg::CordW-1:0]  x_q, x_d, y_q, y_d;
  logic [31:0]                       z_q, z_d;

  logic signed [16:0]                xe, ye, xa, ya;
  logic signed [30:0]                xsc, ysc;
  logic signed [sch_pkg::CordW-1:0]  xs, ys;
  logic [31:0]                       atan;
  logic [31:0]                       th_off, th_red;
  logic                              cw;

  logic signed [sch_pkg::CordW-1:0]  xo, yo;
  logic signed [sch_pkg::CordW:0]    xr, yr;

  always_comb begin
    xe     = {x_i[15], x_i};
    ye     = {y_i[15], y_i};
    xa     = x_i[15] ? -xe : xe;
    ya     = x_i[15] ? -ye : ye;
    xsc    = {xa, 14'd0};
    ysc    = {ya, 14'd0};
    th_off = theta_i - sch_pkg::TurnQuarter;
    th_red = theta_i - sch_pkg::TurnHalf;
    xs     = x_q >>> step_q;
    ys     = y_q >>> step_q;
    atan   = sch_pkg::atan_lut(step_q);
    cw     = rot_q ? z_q[31] : ~y_q[sch_pkg::CordW-1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rot_d  = rot_q;
    neg_d  = neg_q;
    step_d = step_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (cmd_i.start) begin
      step_d = '0;
      rot_d  = cmd_i.rotate;
      if (cmd_i.rotate) begin
        busy_d = 1'b1;
        x_d    = sch_pkg::CordW'(sch_pkg::InvGainQ30);
        y_d    = '0;
        // fold the left half-plane onto the right one and negate the result later
        if (!th_off[31]) begin
          z_d   = th_red;
          neg_d = 1'b1;
        end else begin
          z_d   = theta_i;
          neg_d = 1'b0;
        end
      end else begin
        neg_d = 1'b0;
        x_d   = {{3{xsc[30]}}, xsc};
        y_d   = {{3{ysc[30]}}, ysc};
        z_d   = x_i[15] ? sch_pkg::TurnHalf : 32'd0;
        if (x_i == 16'sd0 && y_i == 16'sd0) begin
          // zero vector: angle is zero, no iterations
          busy_d = 1'b0;
          done_d = 1'b1;
          z_d    = 32'd0;
        end else begin
          busy_d = 1'b1;
        end
      end
    end else if (busy_q) begin
      if (cw) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan;
      end
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rot_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rot_q  <= rot_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // Q2.30 to Q1.15 with rounding and saturation
  always_comb begin
    xo    = neg_q ? -x_q : x_q;
    yo    = neg_q ? -y_q : y_q;
    xr    = {xo[sch_pkg::CordW-1], xo} + 35'sd16384;
    yr    = {yo[sch_pkg::CordW-1], yo} + 35'sd16384;
    cos_o = sch_pkg::sat16(xr[34:15]);
    sin_o = sch_pkg::sat16(yr[34:15]);
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

### src/sch_decl_div.sv
// Declination conversion from centidegrees to a binary angle by reciprocal multiplication.
module sch_decl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] decl_i,
  output logic               busy_o,
  output logic [31:0]        angle_o
);

  localparam logic [1:0]  PhMul   = 2'd0;
  localparam logic [1:0]  PhRecip = 2'd1;
  localparam logic [1:0]  PhSum   = 2'd2;

  // 2^32 = 119304 * 36000 + 23296, so the rounded angle is 119304*m plus
  // floor((728*m + 562) / 1125); the last division uses ceil(2^36 / 1125).
  localparam logic [31:0] TurnPerCenti = 32'd119304;
  localparam logic [24:0] NumScale     = 25'd728;
  localparam logic [24:0] NumBias      = 25'd562;
  localparam logic [25:0] Recip1125    = 26'd61083980;

  logic              busy_q, busy_d;
  logic [1:0]        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [15:0]       mag_q, mag_d;
  logic [24:0]       num_q, num_d;
  logic [31:0]       base_q, base_d;
  logic [14:0]       quo_q, quo_d;
  logic [31:0]       angle_q, angle_d;

  logic [15:0]       mag;
  logic [24:0]       num;
  logic [31:0]       base;
  logic [50:0]       prod;
  logic [31:0]       sum;

  always_comb begin
    mag  = decl_i[15] ? 16'(-decl_i) : decl_i;
    num  = {9'd0, mag_q} * NumScale + NumBias;
    base = {16'd0, mag_q} * TurnPerCenti;
    prod = {26'd0, num_q} * {25'd0, Recip1125};
    sum  = base_q + {17'd0, quo_q};
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    num_d   = num_q;
    base_d  = base_q;
    quo_d   = quo_q;
    angle_d = angle_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = PhMul;
      neg_d   = decl_i[15];
      mag_d   = mag;
    end else if (busy_q) begin
      phase_d = phase_q + 1'b1;
      case (phase_q)
        PhMul: begin
          num_d  = num;
          base_d = base;
        end
        PhRecip: quo_d = prod[50:36];
        PhSum: begin
          angle_d = neg_q ? -sum : sum;
          busy_d  = 1'b0;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      angle_q <= 32'd0;
      phase_q <= PhMul;
    end else begin
      busy_q  <= busy_d;
      angle_q <= angle_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    num_q  <= num_d;
    base_q <= base_d;
    quo_q  <= quo_d;
  end

  assign busy_o  = busy_q;
  assign angle_o = angle_q;

endmodule

### src/smoothed_compass_heading_unit.sv
// The single CORDIC unit runs angle, sine/cosine and smoothed-angle passes in turn; a zero vector
// skips the iterations of its pass. A new sample is taken only in the idle state, once the previous
// sample's heading has been placed in the output register.
// A declination write keeps s_axis_tready low while it is converted.
// Reset: gain 64, declination 0, smoothed vector (sine 0, cosine 32767), output empty.
module smoothed_compass_heading_unit #(
  parameter int CORDIC_STEPS = sch_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] mag_x, [31:16] mag_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] heading_centideg
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StVec1   = 4'd1;
  localparam logic [3:0] StRot    = 4'd2;
  localparam logic [3:0] StMulS   = 4'd3;
  localparam logic [3:0] StAddS   = 4'd4;
  localparam logic [3:0] StMulC   = 4'd5;
  localparam logic [3:0] StAddC   = 4'd6;
  localparam logic [3:0] StVStart = 4'd7;
  localparam logic [3:0] StVec2   = 4'd8;
  localparam logic [3:0] StMulH   = 4'd9;
  localparam logic [3:0] StHead   = 4'd10;

  localparam logic signed [16:0] CentiTurn = 17'sd36000;

  logic [3:0]          state_q, state_d;
  logic [8:0]          gain_q;
  logic signed [15:0]  sm_sin_q, sm_sin_d;
  logic signed [15:0]  sm_cos_q, sm_cos_d;
  logic signed [49:0]  prod_q;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_data_q, out_data_d;

  sch_pkg::cordic_cmd_t cmd;
  logic signed [15:0]  cx, cy;
  logic [31:0]         theta;
  logic                c_done;
  logic [31:0]         c_angle;
  logic signed [15:0]  c_sin, c_cos;

  logic                decl_start;
  logic                div_busy;
  logic [31:0]         decl_ang;

  logic [8:0]          gain_eff;
  logic signed [16:0]  diff_s, diff_c;
  logic signed [32:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [49:0]  mul_p;
  logic [48:0]         hsum;
  logic [16:0]         hraw;
  logic [15:0]         head;
  logic                in_acc;

  function automatic logic signed [15:0] smooth_apply(input logic signed [15:0] old,
                                                      input logic signed [49:0] prod);
    logic signed [26:0] p;
    logic signed [26:0] sh;
    logic signed [19:0] r;
    p  = prod[26:0] + 27'sd128;
    sh = p >>> 8;
    r  = {{4{old[15]}}, old} + sh[19:0];
    return sch_pkg::sat16(r);
  endfunction

  sch_cordic #(
    .Steps(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .x_i     (cx),
    .y_i     (cy),
    .theta_i (theta),
    .done_o  (c_done),
    .angle_o (c_angle),
    .sin_o   (c_sin),
    .cos_o   (c_cos)
  );

  assign decl_start = cfg_we_i && (cfg_idx_i == sch_pkg::RegDecl);

  sch_decl_div u_decl_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (decl_start),
    .decl_i  (cfg_data_i),
    .busy_o  (div_busy),
    .angle_o (decl_ang)
  );

  assign s_axis_tready = (state_q == StIdle) && !div_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Shared multiplier: smoothing products, then angle to centidegrees
  always_comb begin
    gain_eff = (gain_q > sch_pkg::GainMax) ? sch_pkg::GainMax : gain_q;
    diff_s   = {c_sin[15], c_sin} - {sm_sin_q[15], sm_sin_q};
    diff_c   = {c_cos[15], c_cos} - {sm_cos_q[15], sm_cos_q};
    case (state_q)
      StMulS: begin
        mul_a = {{16{diff_s[16]}}, diff_s};
        mul_b = {8'd0, gain_eff};
      end
      StMulC: begin
        mul_a = {{16{diff_c[16]}}, diff_c};
        mul_b = {8'd0, gain_eff};
      end
      default: begin
        mul_a = {1'b0, c_angle};
        mul_b = CentiTurn;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    hsum = {1'b0, prod_q[47:0]} + 49'h0_8000_0000;
    hraw = hsum[48:32];
    head = (hraw >= 17'd36000) ? 16'd0 : hraw[15:0];
  end

  always_comb begin
    state_d     = state_q;
    sm_sin_d    = sm_sin_q;
    sm_cos_d    = sm_cos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cmd.start   = 1'b0;
    cmd.rotate  = 1'b0;
    cx          = sm_cos_q;
    cy          = sm_sin_q;
    theta       = c_angle + decl_ang;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        cx = s_axis_tdata[15:0];
        cy = s_axis_tdata[31:16];
        if (in_acc) begin
          cmd.start = 1'b1;
          state_d   = StVec1;
        end
      end
      StVec1: begin
        if (c_done) begin
          cmd.start  = 1'b1;
          cmd.rotate = 1'b1;
          state_d    = StRot;
        end
      end
      StRot: begin
        if (c_done) begin
          state_d = StMulS;
        end
      end
      StMulS: state_d = StAddS;
      StAddS: begin
        sm_sin_d = smooth_apply(sm_sin_q, prod_q);
        state_d  = StMulC;
      end
      StMulC: state_d = StAddC;
      StAddC: begin
        sm_cos_d = smooth_apply(sm_cos_q, prod_q);
        state_d  = StVStart;
      end
      StVStart: begin
        cmd.start = 1'b1;
        state_d   = StVec2;
      end
      StVec2: begin
        if (c_done) begin
          state_d = StMulH;
        end
      end
      StMulH: state_d = StHead;
      StHead: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = head;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gain_q      <= sch_pkg::GainReset;
      sm_sin_q    <= sch_pkg::SineReset;
      sm_cos_q    <= sch_pkg::CosReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sm_sin_q    <= sm_sin_d;
      sm_cos_q    <= sm_cos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == sch_pkg::RegGain)) begin
        gain_q <= cfg_data_i[8:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= mul_p;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### verif/tb.sv
// Testbench for the smoothed compass heading unit: directed and random stream traffic against a bit-true predictor.
`timescale 1ns / 1ps

module tb;

  localparam int CordicSteps = 16;
  localparam int UsedSteps   = (CordicSteps > sch_pkg::MaxSteps) ? sch_pkg::MaxSteps
                                                                 : CordicSteps;
  localparam int SettleCycles = 3 * CordicSteps + 30;
  localparam int PhaseItems  = 210;
  localparam longint TimeoutNs = 64'd24_000_000;

  // atan(2^-i) in binary angle units, entry 0 in the lowest word
  localparam logic [23:0][31:0] AtanTab = {
    32'h0000_0051, 32'h0000_00A3, 32'h0000_0146, 32'h0000_028C,
    32'h0000_0518, 32'h0000_0A30, 32'h0000_145F, 32'h0000_28BE,
    32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
    32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
    32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
    32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;   // [15:0] mag_x, [31:16] mag_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] heading_centideg
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = sch_pkg::RegDecl;
  logic [15:0] cfg_data_i = 16'd0;

  smoothed_compass_heading_unit #(
    .CORDIC_STEPS(CordicSteps)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Predictor copy of configuration and smoothed vector
  logic signed [15:0] decl_reg = 16'sd0;
  logic [8:0]         gain_reg = sch_pkg::GainReset;
  logic signed [15:0] sm_sine  = sch_pkg::SineReset;
  logic signed [15:0] sm_cos   = sch_pkg::CosReset;

  logic [31:0] sample_q[$];
  logic [15:0] heading_q[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  bit   [31:0] sweep_ang = 32'd0;

  function automatic logic signed [15:0] clamp_q15(longint v);
    longint r;
    r = v;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic bit [31:0] vector_angle(longint x, longint y);
    bit [31:0] z;
    longint    xs, ys;
    int        i;
    z = 32'd0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = sch_pkg::TurnHalf;
    end
    x = x * 16384;
    y = y * 16384;
    for (i = 0; i < UsedSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanTab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanTab[i];
      end
    end
    return z;
  endfunction

  function automatic void unit_vector(input bit [31:0] theta,
                                      output logic signed [15:0] s,
                                      output logic signed [15:0] c);
    bit [31:0] t, off;
    bit        flip;
    longint    x, y, z, xs, ys;
    int        i;
    t = theta;
    flip = 1'b0;
    off = t - sch_pkg::TurnQuarter;
    // fold the left half-plane onto the right and negate afterwards
    if (off < sch_pkg::TurnHalf) begin
      t = t - sch_pkg::TurnHalf;
      flip = 1'b1;
    end
    z = longint'($signed(t));
    x = longint'(sch_pkg::InvGainQ30);
    y = 0;
    for (i = 0; i < UsedSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(AtanTab[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(AtanTab[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = clamp_q15((y + 16384) >>> 15);
    c = clamp_q15((x + 16384) >>> 15);
  endfunction

  function automatic logic signed [15:0] ema_update(logic signed [15:0] old_v,
                                                    logic signed [15:0] tgt, longint g);
    return clamp_q15(longint'(old_v) +
                     ((g * (longint'(tgt) - longint'(old_v)) + 128) >>> 8));
  endfunction

  function automatic bit [31:0] decl_bangle(logic signed [15:0] d);
    longint m, b;
    m = (d < 0) ? -longint'(d) : longint'(d);
    b = ((m <<< 32) + 18000) / 36000;
    if (d < 0) b = -b;
    return b[31:0];
  endfunction

  function automatic logic [15:0] predict_heading(logic [31:0] word);
    logic signed [15:0] s, c;
    longint             g;
    bit [31:0]          ang;
    bit [63:0]          h;
    g = (gain_reg > sch_pkg::GainMax) ? 256 : longint'(gain_reg);
    ang = vector_angle(longint'($signed(word[15:0])), longint'($signed(word[31:16])))
          + decl_bangle(decl_reg);
    unit_vector(ang, s, c);
    sm_sine = ema_update(sm_sine, s, g);
    sm_cos  = ema_update(sm_cos, c, g);
    ang = vector_angle(longint'(sm_cos), longint'(sm_sine));
    h = ({32'd0, ang} * 64'd36000 + 64'h8000_0000) >> 32;
    if (h >= 64'd36000) h = 64'd0;
    return h[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // Sender: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) heading_q.push_back(predict_heading(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_axis_tdata  <= sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 75);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall patterns, plus long hold-offs
  int          rx_cyc = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  logic [15:0] stall_pat = 16'hFFFF;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cyc++;
      if ((rx_cyc % 256) == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom) | 16'($urandom);
          default: stall_pat = 16'($urandom) & 16'($urandom) | 16'h0001;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 30) begin
        // hold off long enough for the input side to back up
        long_hold_done = 1'b1;
        hold_left = 600;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 2999) == 0) begin
        hold_left = $urandom_range(100, 400);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= stall_pat[rx_cyc % 16];
      end
    end
  end

  logic [15:0] want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (heading_q.size() == 0) begin
        report_mismatch($sformatf("unexpected heading %0d", m_axis_tdata));
      end else begin
        want = heading_q.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("heading_centideg got %0d want %0d", m_axis_tdata, want));
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == sch_pkg::RegDecl) decl_reg = $signed(val);
    else gain_reg = val[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_axis_tvalid || heading_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_sample(input int x, input int y);
    sample_q.push_back({16'(y), 16'(x)});
  endtask

  function automatic int to_word_range(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic queue_random(input int n);
    logic signed [15:0] s, c;
    int                 k, sel, sh, xi, yi;
    int                 corner[5];
    corner = '{-32768, -1, 0, 1, 32767};
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // slowly turning field with noise and varying strength
        if ($urandom_range(0, 49) == 0) sweep_ang = $urandom;
        else sweep_ang = sweep_ang + 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        unit_vector(sweep_ang, s, c);
        sh = $urandom_range(0, 8);
        xi = to_word_range((int'(c) >>> sh) + $urandom_range(0, 64) - 32);
        yi = to_word_range((int'(s) >>> sh) + $urandom_range(0, 64) - 32);
        push_sample(xi, yi);
      end else if (sel < 75) begin
        sample_q.push_back($urandom);
      end else if (sel < 85) begin
        push_sample($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
      end else if (sel < 92) begin
        push_sample(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]);
      end else if (sel < 96) begin
        push_sample(0, $urandom_range(0, 65535) - 32768);
      end else begin
        push_sample($urandom_range(0, 65535) - 32768, 0);
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] decl, input logic [15:0] gain, input int n);
    wait_drained();
    write_reg(sch_pkg::RegDecl, decl);
    write_reg(sch_pkg::RegGain, gain);
    queue_random(n);
  endtask

  initial begin
    #(TimeoutNs);
    $display("tb failed");
    $finish;
  end

  initial begin
    int p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: state should stay near the reset vector
    push_sample(100, 0);
    push_sample(0, 0);
    wait_drained();
    // half gain toward the opposite direction drives the smoothed vector to zero
    write_reg(sch_pkg::RegGain, 16'd128);
    push_sample(-100, 0);
    push_sample(0, 0);
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(0, 32767);
    push_sample(0, -32768);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    push_sample(-32768, 32767);
    push_sample(32767, -32768);
    push_sample(1, 0);
    push_sample(-1, 0);
    push_sample(0, 1);
    push_sample(0, -1);
    push_sample(-1, -1);
    push_sample(1, 1);
    push_sample(-32768, -1);
    push_sample(-1, -32768);
    push_sample(300, -40);

    run_phase(16'sd18000, 16'd256, PhaseItems);
    run_phase(-16'sd18000, 16'd1, PhaseItems);
    run_phase(16'sd32767, 16'd0, PhaseItems);
    run_phase(16'h8000, 16'd511, PhaseItems);
    run_phase(16'sd0, 16'd64, PhaseItems);
    run_phase(-16'sd1, 16'd257, PhaseItems);
    for (p = 0; p < 3; p++)
      run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 256)), PhaseItems);

    wait_drained();
    if (mismatch_count == 0 && heading_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
